// ----- rtl/bpe_pkg.sv -----
// ----------------------------------------------------------------------------
// bpe_pkg: shared types and constants
// Word formats, controller command set and fixed field widths for the
// bivariate polynomial evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

	// fixed widths of the arithmetic
	localparam int OP_W   = 48;	// Q31.16 operand / result
	localparam int PROD_W = 96;	// full magnitude product
	localparam int ACC_W  = 56;	// exact sum of saturated terms
	localparam int DIG_W  = 16;	// multiplier digit
	localparam int EXP_W  = 4;	// exponent field, covers degree up to 8
	localparam int FAC_W  = 6;	// derivative factor, up to 8*7
	localparam int ADDR_W = 6;	// coefficient address, up to 45 entries

	// multiplier operand selection
	localparam logic [1:0] OP_POW_X = 2'd0;
	localparam logic [1:0] OP_POW_Y = 2'd1;
	localparam logic [1:0] OP_MONO  = 2'd2;
	localparam logic [1:0] OP_TERM  = 2'd3;

	// result kinds (accumulator index)
	localparam logic [2:0] K_VAL = 3'd0;
	localparam logic [2:0] K_DX  = 3'd1;
	localparam logic [2:0] K_DY  = 3'd2;
	localparam logic [2:0] K_DXX = 3'd3;
	localparam logic [2:0] K_DXY = 3'd4;
	localparam logic [2:0] K_DYY = 3'd5;

	// input word
	typedef struct packed {
		logic               action;
		logic [3:0]         coeff_index;
		logic signed [31:0] coeff_value;
		logic signed [15:0] x_coord;
		logic signed [15:0] y_coord;
	} req_t;

	// result word
	typedef struct packed {
		logic signed [47:0] value;
		logic signed [47:0] d_dx;
		logic signed [47:0] d_dy;
		logic signed [47:0] d_dxx;
		logic signed [47:0] d_dxy;
		logic signed [47:0] d_dyy;
		logic               saturated;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic              load_wr;
		logic              eval_start;
		logic              mul_start;
		logic [1:0]        op;
		logic              pow_wr;
		logic              mono_cap;
		logic              acc_add;
		logic              out_load;
		logic [EXP_W-1:0]  pow_n;
		logic [EXP_W-1:0]  ea;
		logic [EXP_W-1:0]  eb;
		logic [FAC_W-1:0]  fac;
		logic [2:0]        kind;
		logic [ADDR_W-1:0] coef_addr;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mul_busy;
		logic mul_done;
	} stat_t;

endpackage

// ----- rtl/bpe_mul.sv -----
// ----------------------------------------------------------------------------
// bpe_mul: multi-cycle fixed-point multiplier
// Signed 48 x 48 multiply in sign-magnitude, one 16-bit digit of b per cycle,
// then round half away from zero, shift right by 12 or 16 and saturate.
// ----------------------------------------------------------------------------
module bpe_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [bpe_pkg::OP_W-1:0]   a,
	input  logic signed [bpe_pkg::OP_W-1:0]   b,
	input  logic                              sh16,
	output logic signed [bpe_pkg::OP_W-1:0]   res,
	output logic                              sat,
	output logic                              done,
	output logic                              busy
);

	localparam logic [1:0] M_IDLE = 2'd0;
	localparam logic [1:0] M_MUL  = 2'd1;
	localparam logic [1:0] M_RND  = 2'd2;
	localparam logic [1:0] M_SAT  = 2'd3;

	localparam logic [bpe_pkg::OP_W-1:0] LIM_POS = {1'b0, {(bpe_pkg::OP_W-1){1'b1}}};
	localparam logic [bpe_pkg::OP_W-1:0] LIM_NEG = {1'b1, {(bpe_pkg::OP_W-1){1'b0}}};

	logic [1:0]                    state_q;
	logic [1:0]                    cnt_q;
	logic [bpe_pkg::OP_W-1:0]      mag_a_q, mag_b_q;
	logic                          neg_q, sh16_q;
	logic [bpe_pkg::PROD_W-1:0]    prod_q, rnd_q;
	logic signed [bpe_pkg::OP_W-1:0] res_q;
	logic                          sat_q, done_q;

	logic [bpe_pkg::OP_W+bpe_pkg::DIG_W-1:0] pp;
	logic [bpe_pkg::PROD_W-1:0]    rsum;
	logic [bpe_pkg::OP_W-1:0]      lim, mag;
	logic                          over;

	// one digit partial product
	assign pp = mag_a_q * mag_b_q[cnt_q*bpe_pkg::DIG_W +: bpe_pkg::DIG_W];

	// rounding add
	assign rsum = prod_q + (sh16_q ? (bpe_pkg::PROD_W'(1) << 15) : (bpe_pkg::PROD_W'(1) << 11));

	// clipping to the signed 48-bit range
	assign lim  = neg_q ? LIM_NEG : LIM_POS;
	assign over = rnd_q > bpe_pkg::PROD_W'(lim);
	assign mag  = over ? lim : rnd_q[bpe_pkg::OP_W-1:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: if (start) state_q <= M_MUL;
				M_MUL:  if (cnt_q == 2'd2) state_q <= M_RND;
				M_RND:  state_q <= M_SAT;
				M_SAT: begin
					state_q <= M_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			M_IDLE: begin
				if (start) begin
					mag_a_q <= a[bpe_pkg::OP_W-1] ? -a : a;
					mag_b_q <= b[bpe_pkg::OP_W-1] ? -b : b;
					neg_q   <= a[bpe_pkg::OP_W-1] ^ b[bpe_pkg::OP_W-1];
					sh16_q  <= sh16;
					prod_q  <= '0;
					cnt_q   <= '0;
				end
			end
			M_MUL: begin
				prod_q <= prod_q + (bpe_pkg::PROD_W'(pp) << (bpe_pkg::DIG_W * cnt_q));
				cnt_q  <= cnt_q + 2'd1;
			end
			M_RND: rnd_q <= sh16_q ? (rsum >> 16) : (rsum >> 12);
			M_SAT: begin
				res_q <= neg_q ? -$signed(mag) : $signed(mag);
				sat_q <= over;
			end
			default: ;
		endcase
	end

	assign res  = res_q;
	assign sat  = sat_q;
	assign done = done_q;
	assign busy = (state_q != M_IDLE);

endmodule

// ----- rtl/bpe_dp.sv -----
// ----------------------------------------------------------------------------
// bpe_dp: evaluator datapath
// Coefficient memory, power tables, shared multiplier, six accumulators and
// the result register.
// ----------------------------------------------------------------------------
module bpe_dp #(
	parameter int MAX_DEGREE = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bpe_pkg::req_t   req,
	input  bpe_pkg::cmd_t   cmd,
	output bpe_pkg::stat_t  stat,
	output bpe_pkg::rsp_t   rsp
);

	localparam int NCOEF = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
	localparam int AW    = $clog2(NCOEF);
	localparam int DW    = $clog2(MAX_DEGREE + 1);
	localparam logic signed [bpe_pkg::ACC_W-1:0] LIM_HI =
		bpe_pkg::ACC_W'({1'b0, {(bpe_pkg::OP_W-1){1'b1}}});
	localparam logic signed [bpe_pkg::ACC_W-1:0] LIM_LO = -LIM_HI - 1;

	logic [31:0]                         mem [0:NCOEF-1];
	logic signed [31:0]                  rd_q;
	logic signed [15:0]                  x_q, y_q;
	logic signed [bpe_pkg::OP_W-1:0]     px_q [0:MAX_DEGREE];
	logic signed [bpe_pkg::OP_W-1:0]     py_q [0:MAX_DEGREE];
	logic signed [bpe_pkg::OP_W-1:0]     mono_q;
	logic signed [bpe_pkg::ACC_W-1:0]    acc_q [0:5];
	logic                                sat_q;
	bpe_pkg::rsp_t                       rsp_q;

	logic [7:0]                          wr_idx;
	logic [7:0]                          rd_idx;
	logic [bpe_pkg::EXP_W-1:0]           pm1;
	logic signed [38:0]                  ck;
	logic signed [bpe_pkg::OP_W-1:0]     op_a, op_b;
	logic                                op_sh16;
	logic signed [bpe_pkg::OP_W-1:0]     mul_res;
	logic                                mul_sat, mul_done, mul_busy;
	logic signed [bpe_pkg::OP_W-1:0]     fin [0:5];
	logic [5:0]                          clip;

	assign wr_idx = {4'b0, req.coeff_index};
	assign rd_idx = 8'(cmd.coef_addr);
	assign pm1    = cmd.pow_n - 1'b1;
	assign ck     = rd_q * $signed({1'b0, cmd.fac});

	// coefficient memory
	always_ff @(posedge clk) begin
		if (cmd.load_wr && (32'(wr_idx) < NCOEF))
			mem[wr_idx[AW-1:0]] <= req.coeff_value;
		rd_q <= mem[rd_idx[AW-1:0]];
	end

	// multiplier operand selection
	always_comb begin
		op_a    = '0;
		op_b    = '0;
		op_sh16 = 1'b1;
		unique case (cmd.op)
			bpe_pkg::OP_POW_X: begin
				op_a    = px_q[pm1[DW-1:0]];
				op_b    = bpe_pkg::OP_W'(x_q);
				op_sh16 = 1'b0;
			end
			bpe_pkg::OP_POW_Y: begin
				op_a    = py_q[pm1[DW-1:0]];
				op_b    = bpe_pkg::OP_W'(y_q);
				op_sh16 = 1'b0;
			end
			bpe_pkg::OP_MONO: begin
				op_a = px_q[cmd.ea[DW-1:0]];
				op_b = py_q[cmd.eb[DW-1:0]];
			end
			bpe_pkg::OP_TERM: begin
				op_a = bpe_pkg::OP_W'(ck);
				op_b = mono_q;
			end
			default: ;
		endcase
	end

	bpe_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.a     (op_a),
		.b     (op_b),
		.sh16  (op_sh16),
		.res   (mul_res),
		.sat   (mul_sat),
		.done  (mul_done),
		.busy  (mul_busy)
	);

	assign stat.mul_busy = mul_busy;
	assign stat.mul_done = mul_done;

	// point, powers, monomial, accumulators and clip flag
	always_ff @(posedge clk) begin
		if (cmd.eval_start) begin
			x_q      <= req.x_coord;
			y_q      <= req.y_coord;
			px_q[0]  <= bpe_pkg::OP_W'(65536);
			py_q[0]  <= bpe_pkg::OP_W'(65536);
			sat_q    <= 1'b0;
			for (int k = 0; k < 6; k++)
				acc_q[k] <= '0;
		end else begin
			if (mul_done && mul_sat)
				sat_q <= 1'b1;
			if (cmd.pow_wr && cmd.op == bpe_pkg::OP_POW_X)
				px_q[cmd.pow_n[DW-1:0]] <= mul_res;
			if (cmd.pow_wr && cmd.op == bpe_pkg::OP_POW_Y)
				py_q[cmd.pow_n[DW-1:0]] <= mul_res;
			if (cmd.mono_cap)
				mono_q <= mul_res;
			if (cmd.acc_add)
				acc_q[cmd.kind] <= acc_q[cmd.kind] + bpe_pkg::ACC_W'(mul_res);
		end
	end

	// final clipping of the sums
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			clip[k] = 1'b1;
			if (acc_q[k] > LIM_HI)
				fin[k] = LIM_HI[bpe_pkg::OP_W-1:0];
			else if (acc_q[k] < LIM_LO)
				fin[k] = LIM_LO[bpe_pkg::OP_W-1:0];
			else begin
				fin[k]  = acc_q[k][bpe_pkg::OP_W-1:0];
				clip[k] = 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.value     <= fin[bpe_pkg::K_VAL];
			rsp_q.d_dx      <= fin[bpe_pkg::K_DX];
			rsp_q.d_dy      <= fin[bpe_pkg::K_DY];
			rsp_q.d_dxx     <= fin[bpe_pkg::K_DXX];
			rsp_q.d_dxy     <= fin[bpe_pkg::K_DXY];
			rsp_q.d_dyy     <= fin[bpe_pkg::K_DYY];
			rsp_q.saturated <= sat_q | (|clip);
		end
	end

	assign rsp = rsp_q;

endmodule

// ----- rtl/bpe_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpe_ctrl: evaluator controller
// Handshakes, degree register and the sequence of powers, monomials and
// weighted terms for each evaluation.
// ----------------------------------------------------------------------------
module bpe_ctrl #(
	parameter int MAX_DEGREE = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  logic            req_action,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_data,
	input  bpe_pkg::stat_t  stat,
	output bpe_pkg::cmd_t   cmd
);

	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int EW = bpe_pkg::EXP_W;
	localparam int FW = bpe_pkg::FAC_W;

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_POW_GO    = 3'd1;
	localparam logic [2:0] S_POW_WAIT  = 3'd2;
	localparam logic [2:0] S_CHK       = 3'd3;
	localparam logic [2:0] S_MON_WAIT  = 3'd4;
	localparam logic [2:0] S_TERM_GO   = 3'd5;
	localparam logic [2:0] S_TERM_WAIT = 3'd6;
	localparam logic [2:0] S_FIN       = 3'd7;

	logic [2:0]                  state_q;
	logic [2:0]                  deg_q;
	logic [DW-1:0]               i_q, j_q, n_q;
	logic [2:0]                  kind_q;
	logic                        ysel_q;
	logic [bpe_pkg::ADDR_W-1:0]  addr_q;
	logic                        out_full_q;

	logic [DW-1:0]  deg_eff;
	logic [EW-1:0]  a, b;
	logic [FW-1:0]  fa, fb;
	logic [EW-1:0]  ea_k, eb_k;
	logic [FW-1:0]  fac_k;
	logic           kval, last_term, advance, accept;

	assign deg_eff = (int'(deg_q) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(deg_q);
	assign a  = EW'(i_q) - EW'(j_q);
	assign b  = EW'(j_q);
	assign fa = FW'(a);
	assign fb = FW'(b);

	assign accept    = req_valid && !req_stall;
	assign last_term = (j_q == i_q) && (i_q == deg_eff) && (kind_q == bpe_pkg::K_DYY);
	assign advance   = (state_q == S_CHK && !kval) ||
	                   (state_q == S_TERM_WAIT && stat.mul_done);

	// exponents and factor of the current term kind
	always_comb begin
		kval  = 1'b0;
		ea_k  = a;
		eb_k  = b;
		fac_k = FW'(1);
		unique case (kind_q)
			bpe_pkg::K_VAL: kval = 1'b1;
			bpe_pkg::K_DX: begin
				kval  = (a >= EW'(1));
				ea_k  = a - EW'(1);
				fac_k = fa;
			end
			bpe_pkg::K_DY: begin
				kval  = (b >= EW'(1));
				eb_k  = b - EW'(1);
				fac_k = fb;
			end
			bpe_pkg::K_DXX: begin
				kval  = (a >= EW'(2));
				ea_k  = a - EW'(2);
				fac_k = fa * (fa - FW'(1));
			end
			bpe_pkg::K_DXY: begin
				kval  = (a >= EW'(1)) && (b >= EW'(1));
				ea_k  = a - EW'(1);
				eb_k  = b - EW'(1);
				fac_k = fa * fb;
			end
			bpe_pkg::K_DYY: begin
				kval  = (b >= EW'(2));
				eb_k  = b - EW'(2);
				fac_k = fb * (fb - FW'(1));
			end
			default: ;
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd.load_wr    = 1'b0;
		cmd.eval_start = 1'b0;
		cmd.mul_start  = 1'b0;
		cmd.op         = bpe_pkg::OP_MONO;
		cmd.pow_wr     = 1'b0;
		cmd.mono_cap   = 1'b0;
		cmd.acc_add    = 1'b0;
		cmd.out_load   = 1'b0;
		cmd.pow_n      = EW'(n_q);
		cmd.ea         = ea_k;
		cmd.eb         = eb_k;
		cmd.fac        = fac_k;
		cmd.kind       = kind_q;
		cmd.coef_addr  = addr_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_wr    = accept && !req_action;
				cmd.eval_start = accept && req_action;
			end
			S_POW_GO: begin
				cmd.mul_start = 1'b1;
				cmd.op        = ysel_q ? bpe_pkg::OP_POW_Y : bpe_pkg::OP_POW_X;
			end
			S_POW_WAIT: begin
				cmd.pow_wr = stat.mul_done;
				cmd.op     = ysel_q ? bpe_pkg::OP_POW_Y : bpe_pkg::OP_POW_X;
			end
			S_CHK:       cmd.mul_start = kval;
			S_MON_WAIT:  cmd.mono_cap  = stat.mul_done;
			S_TERM_GO: begin
				cmd.mul_start = 1'b1;
				cmd.op        = bpe_pkg::OP_TERM;
			end
			S_TERM_WAIT: cmd.acc_add  = stat.mul_done;
			S_FIN:       cmd.out_load = !out_full_q || !rsp_stall;
			default: ;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			deg_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			n_q     <= '0;
			kind_q  <= '0;
			ysel_q  <= 1'b0;
			addr_q  <= '0;
		end else begin
			if (cfg_valid)
				deg_q <= cfg_data;
			if (advance) begin
				if (kind_q == bpe_pkg::K_DYY) begin
					kind_q <= bpe_pkg::K_VAL;
					addr_q <= addr_q + 1'b1;
					if (j_q != i_q)
						j_q <= j_q + 1'b1;
					else begin
						i_q <= i_q + 1'b1;
						j_q <= '0;
					end
				end else
					kind_q <= kind_q + 3'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && req_action) begin
						state_q <= S_POW_GO;
						i_q     <= '0;
						j_q     <= '0;
						kind_q  <= bpe_pkg::K_VAL;
						addr_q  <= '0;
						n_q     <= DW'(1);
						ysel_q  <= 1'b0;
					end
				end
				S_POW_GO: state_q <= S_POW_WAIT;
				S_POW_WAIT: begin
					if (stat.mul_done) begin
						if (!ysel_q) begin
							ysel_q  <= 1'b1;
							state_q <= S_POW_GO;
						end else if (int'(n_q) == MAX_DEGREE) begin
							state_q <= S_CHK;
						end else begin
							ysel_q  <= 1'b0;
							n_q     <= n_q + 1'b1;
							state_q <= S_POW_GO;
						end
					end
				end
				S_CHK: begin
					if (kval)
						state_q <= S_MON_WAIT;
					else if (last_term)
						state_q <= S_FIN;
				end
				S_MON_WAIT: if (stat.mul_done) state_q <= S_TERM_GO;
				S_TERM_GO:  state_q <= S_TERM_WAIT;
				S_TERM_WAIT: begin
					if (stat.mul_done)
						state_q <= last_term ? S_FIN : S_CHK;
				end
				S_FIN: if (!out_full_q || !rsp_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result word held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_full_q <= 1'b0;
		else
			out_full_q <= cmd.out_load || (out_full_q && rsp_stall);
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_full_q;
	assign cfg_ready = 1'b1;

	// the shared multiplier is only started when free
	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !stat.mul_busy)
		else $error("multiplier started while busy");

	// a finished result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_full_q && rsp_stall))
		else $error("result overwritten");

	// an accepted evaluation leaves idle
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_action) |=> (state_q == S_POW_GO))
		else $error("evaluation not started");

	// a load never starts work
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !req_action) |=> (state_q == S_IDLE))
		else $error("load left idle");

endmodule

// ----- rtl/bivariate_poly_eval_derivs.sv -----
// ----------------------------------------------------------------------------
// bivariate_poly_eval_derivs: polynomial value and partials at a point
// Stores graded coefficients and evaluates value, dx, dy, dxx, dxy, dyy in
// fixed point with saturation.
//
//   channel  signals                     direction  word
//   req      req_valid/req_stall, req    in         load or evaluate
//   rsp      rsp_valid/rsp_stall, rsp    out        value, partials, flag
//   cfg      cfg_valid/cfg_ready, cfg_data in       poly_degree
//
// A load is written straight into the coefficient memory. An evaluation first
// computes the powers of x and y up to MAX_DEGREE, one multiply each, then per
// coefficient makes two passes of the shared multiplier for each nonzero
// derivative kind and skips each kind that is zero, then writes the result: the
// single multiplier sets the rate.
// The result sits in an output register, so a load is taken while it waits.
// Reset clears only control state; coefficients are undefined until loaded.
// ----------------------------------------------------------------------------
module bivariate_poly_eval_derivs #(
	parameter int MAX_DEGREE = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bpe_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output bpe_pkg::rsp_t  rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_data
);

	bpe_pkg::cmd_t  cmd;
	bpe_pkg::stat_t stat;

	// controller
	bpe_ctrl #(.MAX_DEGREE(MAX_DEGREE)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_action(req.action),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath
	bpe_dp #(.MAX_DEGREE(MAX_DEGREE)) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.stat  (stat),
		.rsp   (rsp)
	);

endmodule
